>>> src/sje_pkg.sv
// sje_pkg: shared types, constants and index maps of the 3x3 jacobi eigen core
// holds the sequencer state enum, arithmetic unit request/response structs
// no dependencies
package sje_pkg;

  localparam int unsigned MATRIX_DIM = 3;
  localparam int unsigned TRI_SIZE   = MATRIX_DIM * (MATRIX_DIM + 1) / 2;
  localparam int unsigned VEC_SIZE   = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned DIV_STEPS  = 62;
  localparam int unsigned SQRT_STEPS = 32;
  localparam logic [5:0]  ZERO_AFTER = 6'd4;

  localparam logic [5:0]  MAX_SWEEPS_RST = 6'd49;
  localparam logic [5:0]  THR_SWEEPS_RST = 6'd3;
  localparam logic [4:0]  NEG_SHIFT_RST  = 5'd24;

  localparam logic [1:0]  REG_MAX_SWEEPS = 2'd0;
  localparam logic [1:0]  REG_THR_SWEEPS = 2'd1;
  localparam logic [1:0]  REG_NEG_SHIFT  = 2'd2;

  localparam logic [1:0]  LAST_PAIR = 2'd2;
  localparam logic [1:0]  LAST_RSTEP = 2'd3;
  localparam logic [1:0]  LAST_IDX  = 2'd2;

  typedef enum logic [1:0] {
    ARITH_MUL,
    ARITH_DIV,
    ARITH_SQRT
  } arith_op_t;

  typedef struct packed {
    logic        start;
    arith_op_t   op;
    logic [63:0] a;
    logic [63:0] b;
  } arith_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } arith_rsp_t;

  typedef enum logic [5:0] {
    S_IDLE, S_INIT, S_SWEEP, S_SUM,
    S_PAIR_LD, S_PAIR_CHK, S_ROT_H, S_SHIFT,
    S_SQ1, S_SQ2, S_R1, S_TDIV, S_TSQI, S_TSQ, S_R2,
    S_CDIV, S_SM, S_TAU, S_HT, S_DIAG_P, S_DIAG_Q,
    S_LDX, S_LDY, S_M1, S_M2I, S_M2, S_M3I, S_M3, S_M4I, S_M4,
    S_WB, S_NEXT, S_SEND, S_EMIT
  } seq_state_t;

  // pair order 01, 02, 12
  function automatic logic [1:0] p_of(input logic [1:0] pr);
    case (pr)
      2'd2:    p_of = 2'd1;
      default: p_of = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] q_of(input logic [1:0] pr);
    case (pr)
      2'd0:    q_of = 2'd1;
      default: q_of = 2'd2;
    endcase
  endfunction

  // triangle slots: 00 01 02 11 12 22
  function automatic logic [2:0] apq_idx(input logic [1:0] pr);
    case (pr)
      2'd0:    apq_idx = 3'd1;
      2'd1:    apq_idx = 3'd2;
      default: apq_idx = 3'd4;
    endcase
  endfunction

  // first off-diagonal touched by the rotation of a pair
  function automatic logic [2:0] x_idx(input logic [1:0] pr);
    case (pr)
      2'd0:    x_idx = 3'd2;
      default: x_idx = 3'd1;
    endcase
  endfunction

  function automatic logic [2:0] y_idx(input logic [1:0] pr);
    case (pr)
      2'd2:    y_idx = 3'd2;
      default: y_idx = 3'd4;
    endcase
  endfunction

  function automatic logic [2:0] diag_idx(input logic [1:0] i);
    case (i)
      2'd0:    diag_idx = 3'd0;
      2'd1:    diag_idx = 3'd3;
      default: diag_idx = 3'd5;
    endcase
  endfunction

  function automatic logic [3:0] vec_idx(input logic [1:0] row, input logic [1:0] col);
    vec_idx = {row, 1'b0} + {2'b00, row} + {2'b00, col};
  endfunction

endpackage

>>> src/symmetric_eigen_jacobi_core.sv
// symmetric_eigen_jacobi_core: cyclic jacobi eigen solver for a 3x3 symmetric matrix
// sequencer, matrix/vector/diagonal stores, config registers and output register
// depends on sje_pkg and sje_arith
//
// usage
//   s_axis carries the upper triangle, one element per transaction:
//   tdata[2:0] element index (00,01,02,11,12,22), tdata[34:3] value in Q16.16.
//   tlast on an element stores it and starts the solve.
//   the solve runs sweeps of rotations on one shared multiply/divide/sqrt
//   unit; a rotation uses up to three 62-step divides and two 32-step
//   square roots, a sweep up to three rotations plus bookkeeping states;
//   the sweep threshold is a shift-add compare.
//   s_axis_tready is low from the start of the solve until the last result
//   has been loaded into the output register.
//   m_axis then gives nine transactions, eigenvalue by eigenvalue and row by
//   row, one per cycle while m_axis_tready stays high; a stalled receiver just
//   holds the output register and the sequencer waits.
//   cfg_write/cfg_index/cfg_data set max_sweeps, threshold_sweeps and
//   negligible_shift; write only while idle.
//   rst (synchronous) restores the register defaults 49, 3, 24 and idles.
module symmetric_eigen_jacobi_core import sje_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // element_index[2:0], element_value[34:3], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // pair_index[1:0], component_index[3:2],
                                      // eigen_value[35:4], vector_component[67:36],
                                      // rotation_count[75:68], converged[76], zero pad
  output logic        m_axis_tlast,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh0_7fff_ffff)      sat32 = 32'sh7fff_ffff;
    else if (v < -36'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else                           sat32 = v[31:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  // config registers
  logic [5:0] max_sweeps;
  logic [5:0] threshold_sweeps;
  logic [4:0] negligible_shift;

  // stores
  logic signed [31:0] mat    [TRI_SIZE];
  logic signed [31:0] vec    [VEC_SIZE];
  logic signed [31:0] dbase  [MATRIX_DIM];
  logic signed [31:0] dcur   [MATRIX_DIM];
  logic signed [31:0] ddelta [MATRIX_DIM];

  seq_state_t state, state_next;

  logic [5:0]  sweep;
  logic [7:0]  rots;
  logic        conv;
  logic [1:0]  pair;
  logic [1:0]  rstep;
  logic [1:0]  ek;
  logic [1:0]  er;

  // rotation working registers
  logic signed [31:0] apq;
  logic signed [31:0] dp;
  logic signed [32:0] h;
  logic [32:0]        hs;
  logic [32:0]        am;
  logic [63:0]        sq;
  logic               tneg;
  logic [30:0]        tm;
  logic [30:0]        cm;
  logic [30:0]        sm;
  logic [30:0]        taum;
  logic signed [32:0] ht;
  logic signed [31:0] gx;
  logic signed [31:0] hx;
  logic signed [32:0] u;
  logic signed [32:0] w;
  logic signed [31:0] xn;
  logic signed [31:0] yn;
  logic               msign;
  // off-diagonal sum of a threshold sweep, zero when no threshold applies
  logic [33:0]        thr_sum;

  // output register
  logic [1:0]  out_pair;
  logic [1:0]  out_comp;
  logic [31:0] out_eig;
  logic [31:0] out_vec;
  logic [7:0]  out_rot;
  logic        out_conv;
  logic        out_last;
  logic        out_valid;

  arith_req_t req;
  arith_rsp_t rsp;

  sje_arith u_arith (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // decode helpers
  logic               s_fire;
  logic [2:0]         in_idx;
  logic signed [31:0] in_val;
  logic [33:0]        sum_c;
  logic               thr_on;
  logic [31:0]        aa;
  logic [38:0]        g_c;
  logic [37:0]        aa45;
  logic signed [31:0] dq_c;
  logic               zero_c;
  logic               rot_c;
  logic [32:0]        hm_c;
  logic               neg_h;
  logic               shift_c;
  logic [33:0]        rden;
  logic [33:0]        mprod;
  logic signed [34:0] mq_c;
  logic               out_load;
  logic               emit_last;
  logic [1:0]         pp;
  logic [1:0]         qq;

  assign s_axis_tready = (state == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign in_idx        = s_axis_tdata[2:0];
  assign in_val        = s_axis_tdata[34:3];

  assign pp      = p_of(pair);
  assign qq      = q_of(pair);
  assign sum_c   = {2'b00, mag32(mat[1])} + {2'b00, mag32(mat[2])} + {2'b00, mag32(mat[4])};
  assign thr_on  = sweep <= threshold_sweeps;
  assign aa      = mag32(apq);
  // 100*|a| as 64+32+4
  assign g_c     = {1'b0, aa, 6'b0} + {2'b00, aa, 5'b0} + {5'b0, aa, 2'b0};
  // 45*|a| as 32+8+4+1
  assign aa45    = {1'b0, aa, 5'b0} + {3'b0, aa, 3'b0} + {4'b0, aa, 2'b0} + {6'b0, aa};
  assign dq_c    = dcur[qq];
  assign zero_c  = (sweep > ZERO_AFTER)
                && (g_c <= {7'b0, mag32(dp) >> negligible_shift})
                && (g_c <= {7'b0, mag32(dq_c) >> negligible_shift});
  // |a| > floor(2*sum/90) is the same as 45*|a| > sum
  assign rot_c   = aa45 > {4'b0, thr_sum};
  assign hm_c    = mag33(h);
  assign neg_h   = g_c <= {6'b0, hm_c >> negligible_shift};
  assign shift_c = (hs[32:31] != 2'b00) || (am[32:31] != 2'b00);
  assign rden    = {1'b0, hs} + {1'b0, rsp.res[32:0]};

  // signed (|v|*|coef|)>>30 from the multiplier result
  assign mprod = rsp.res[63:30];
  assign mq_c  = msign ? -$signed({1'b0, mprod}) : $signed({1'b0, mprod});

  assign out_load  = (state == S_EMIT) && (!out_valid || m_axis_tready);
  assign emit_last = (ek == LAST_IDX) && (er == LAST_IDX);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (s_fire && s_axis_tlast) state_next = S_INIT;
      S_INIT:     state_next = S_SWEEP;
      S_SWEEP:    state_next = (sweep == max_sweeps) ? S_EMIT : S_SUM;
      S_SUM: begin
        if (sum_c == 34'd0) state_next = S_EMIT;
        else                state_next = S_PAIR_LD;
      end
      S_PAIR_LD:  state_next = S_PAIR_CHK;
      S_PAIR_CHK: begin
        if (zero_c)     state_next = S_NEXT;
        else if (rot_c) state_next = S_ROT_H;
        else            state_next = S_NEXT;
      end
      S_ROT_H:    state_next = neg_h ? S_TDIV : S_SHIFT;
      S_SHIFT:    if (!shift_c) state_next = S_SQ1;
      S_SQ1:      if (rsp.done) state_next = S_SQ2;
      S_SQ2:      if (rsp.done) state_next = S_R1;
      S_R1:       if (rsp.done) state_next = (rden == 34'd0) ? S_TSQI : S_TDIV;
      S_TDIV:     if (rsp.done) state_next = S_TSQI;
      S_TSQI:     state_next = S_TSQ;
      S_TSQ:      if (rsp.done) state_next = S_R2;
      S_R2:       if (rsp.done) state_next = S_CDIV;
      S_CDIV:     if (rsp.done) state_next = S_SM;
      S_SM:       if (rsp.done) state_next = S_TAU;
      S_TAU:      if (rsp.done) state_next = S_HT;
      S_HT:       if (rsp.done) state_next = S_DIAG_P;
      S_DIAG_P:   state_next = S_DIAG_Q;
      S_DIAG_Q:   state_next = S_LDX;
      S_LDX:      state_next = S_LDY;
      S_LDY:      state_next = S_M1;
      S_M1:       if (rsp.done) state_next = S_M2I;
      S_M2I:      state_next = S_M2;
      S_M2:       if (rsp.done) state_next = S_M3I;
      S_M3I:      state_next = S_M3;
      S_M3:       if (rsp.done) state_next = S_M4I;
      S_M4I:      state_next = S_M4;
      S_M4:       if (rsp.done) state_next = S_WB;
      S_WB:       state_next = (rstep == LAST_RSTEP) ? S_NEXT : S_LDX;
      S_NEXT:     state_next = (pair == LAST_PAIR) ? S_SEND : S_PAIR_LD;
      S_SEND:     state_next = S_SWEEP;
      S_EMIT:     if (out_load && emit_last) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // requests to the shared arithmetic unit
  always_comb begin
    req.start = 1'b0;
    req.op    = ARITH_MUL;
    req.a     = '0;
    req.b     = '0;
    case (state)
      S_ROT_H: begin
        if (neg_h) begin
          req.start = 1'b1;
          req.op    = ARITH_DIV;
          req.a     = {2'b00, aa, 30'b0};
          req.b     = {31'b0, hm_c};
        end
      end
      S_SHIFT: begin
        if (!shift_c) begin
          req.start = 1'b1;
          req.a     = {31'b0, hs};
          req.b     = {32'b0, hs[31:0]};
        end
      end
      S_SQ1: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.a     = {31'b0, am};
          req.b     = {32'b0, am[31:0]};
        end
      end
      S_SQ2: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = ARITH_SQRT;
          req.a     = sq + rsp.res;
        end
      end
      S_R1: begin
        if (rsp.done && rden != 34'd0) begin
          req.start = 1'b1;
          req.op    = ARITH_DIV;
          req.a     = {1'b0, am, 30'b0};
          req.b     = {30'b0, rden};
        end
      end
      S_TSQI: begin
        req.start = 1'b1;
        req.a     = {33'b0, tm};
        req.b     = {33'b0, tm};
      end
      S_TSQ: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = ARITH_SQRT;
          req.a     = 64'h1000_0000_0000_0000 + rsp.res;
        end
      end
      S_R2: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = ARITH_DIV;
          req.a     = 64'h1000_0000_0000_0000;
          req.b     = {31'b0, rsp.res[32:0]};
        end
      end
      S_CDIV: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.a     = {33'b0, tm};
          req.b     = {32'b0, rsp.res[31:0]};
        end
      end
      S_SM: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.op    = ARITH_DIV;
          req.a     = {3'b000, rsp.res[60:30], 30'b0};
          req.b     = 64'h4000_0000 + {33'b0, cm};
        end
      end
      S_TAU: begin
        if (rsp.done) begin
          req.start = 1'b1;
          req.a     = {32'b0, aa};
          req.b     = {33'b0, tm};
        end
      end
      S_LDY: begin
        req.start = 1'b1;
        req.a     = {32'b0, mag32(gx)};
        req.b     = {33'b0, taum};
      end
      S_M2I: begin
        req.start = 1'b1;
        req.a     = {31'b0, mag33(u)};
        req.b     = {33'b0, sm};
      end
      S_M3I: begin
        req.start = 1'b1;
        req.a     = {32'b0, mag32(hx)};
        req.b     = {33'b0, taum};
      end
      S_M4I: begin
        req.start = 1'b1;
        req.a     = {31'b0, mag33(w)};
        req.b     = {33'b0, sm};
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      max_sweeps       <= MAX_SWEEPS_RST;
      threshold_sweeps <= THR_SWEEPS_RST;
      negligible_shift <= NEG_SHIFT_RST;
      sweep            <= '0;
      rots             <= '0;
      conv             <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_MAX_SWEEPS: max_sweeps       <= cfg_data;
          REG_THR_SWEEPS: threshold_sweeps <= cfg_data;
          REG_NEG_SHIFT:  negligible_shift <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state)
        S_INIT: begin
          sweep <= '0;
          rots  <= '0;
          conv  <= 1'b0;
        end
        S_SWEEP: if (sweep != max_sweeps) sweep <= sweep + 6'd1;
        S_SUM:   if (sum_c == 34'd0) conv <= 1'b1;
        // rotation count saturates
        S_WB:    if (rstep == LAST_RSTEP && rots != 8'hff) rots <= rots + 8'd1;
        default: ;
      endcase
      if (out_load)           out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;
    end
  end

  // datapath and stores
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_fire && in_idx < 3'(TRI_SIZE)) mat[in_idx] <= in_val;
      end
      S_INIT: begin
        for (int i = 0; i < MATRIX_DIM; i++) begin
          dbase[i]  <= mat[diag_idx(2'(i))];
          dcur[i]   <= mat[diag_idx(2'(i))];
          ddelta[i] <= '0;
          for (int j = 0; j < MATRIX_DIM; j++) begin
            vec[vec_idx(2'(i), 2'(j))] <= (i == j) ? 32'sh4000_0000 : 32'sh0;
          end
        end
        ek <= '0;
        er <= '0;
      end
      S_SUM: begin
        pair    <= '0;
        thr_sum <= thr_on ? sum_c : '0;
      end
      S_PAIR_LD: begin
        apq <= mat[apq_idx(pair)];
        dp  <= dcur[pp];
      end
      S_PAIR_CHK: begin
        if (zero_c) mat[apq_idx(pair)] <= '0;
        h <= {dq_c[31], dq_c} - {dp[31], dp};
      end
      S_ROT_H: begin
        if (neg_h) begin
          tneg <= apq[31] != h[32];
        end else begin
          tneg <= (h != 33'sd0) && (apq[31] != h[32]);
          hs   <= hm_c;
          am   <= {aa, 1'b0};
        end
      end
      S_SHIFT: begin
        if (shift_c) begin
          hs <= hs >> 1;
          am <= am >> 1;
        end
      end
      S_SQ1:  if (rsp.done) sq <= rsp.res;
      S_R1:   if (rsp.done && rden == 34'd0) tm <= '0;
      S_TDIV: if (rsp.done) tm <= rsp.res[30:0];
      S_CDIV: if (rsp.done) cm <= rsp.res[30:0];
      S_SM:   if (rsp.done) sm <= rsp.res[60:30];
      S_TAU: begin
        if (rsp.done) begin
          taum  <= rsp.res[30:0];
          msign <= apq[31] ^ tneg;
        end
      end
      S_HT:   if (rsp.done) ht <= mq_c[32:0];
      S_DIAG_P: begin
        dcur[pp]   <= sat32({{4{dcur[pp][31]}}, dcur[pp]} - {{3{ht[32]}}, ht});
        ddelta[pp] <= sat32({{4{ddelta[pp][31]}}, ddelta[pp]} - {{3{ht[32]}}, ht});
      end
      S_DIAG_Q: begin
        dcur[qq]   <= sat32({{4{dcur[qq][31]}}, dcur[qq]} + {{3{ht[32]}}, ht});
        ddelta[qq] <= sat32({{4{ddelta[qq][31]}}, ddelta[qq]} + {{3{ht[32]}}, ht});
        mat[apq_idx(pair)] <= '0;
        rstep <= '0;
      end
      // step 0 rotates the matrix, steps 1..3 the vector rows
      S_LDX: gx <= (rstep == 2'd0) ? mat[x_idx(pair)] : vec[vec_idx(rstep - 2'd1, pp)];
      S_LDY: begin
        hx    <= (rstep == 2'd0) ? mat[y_idx(pair)] : vec[vec_idx(rstep - 2'd1, qq)];
        msign <= gx[31] ^ tneg;
      end
      S_M1:  if (rsp.done) u <= 33'({{3{hx[31]}}, hx} + mq_c);
      S_M2I: msign <= u[32] ^ tneg;
      S_M2:  if (rsp.done) xn <= sat32({{4{gx[31]}}, gx} - {mq_c[34], mq_c});
      S_M3I: msign <= hx[31] ^ tneg;
      S_M3: begin
        if (rsp.done) w <= 33'({{3{gx[31]}}, gx} - mq_c);
      end
      S_M4I: msign <= w[32] ^ tneg;
      S_M4:  if (rsp.done) yn <= sat32({{4{hx[31]}}, hx} + {mq_c[34], mq_c});
      S_WB: begin
        if (rstep == 2'd0) begin
          mat[x_idx(pair)] <= xn;
          mat[y_idx(pair)] <= yn;
        end else begin
          vec[vec_idx(rstep - 2'd1, pp)] <= xn;
          vec[vec_idx(rstep - 2'd1, qq)] <= yn;
        end
        rstep <= rstep + 2'd1;
      end
      S_NEXT: pair <= pair + 2'd1;
      S_SEND: begin
        for (int i = 0; i < MATRIX_DIM; i++) begin
          dbase[i]  <= sat32({{4{dbase[i][31]}}, dbase[i]} + {{4{ddelta[i][31]}}, ddelta[i]});
          dcur[i]   <= sat32({{4{dbase[i][31]}}, dbase[i]} + {{4{ddelta[i][31]}}, ddelta[i]});
          ddelta[i] <= '0;
        end
      end
      default: ;
    endcase

    // result transactions, eigenvalue-major then row
    if (out_load) begin
      out_pair <= ek;
      out_comp <= er;
      out_eig  <= dcur[ek];
      out_vec  <= vec[vec_idx(er, ek)];
      out_rot  <= rots;
      out_conv <= conv;
      out_last <= emit_last;
      if (er == LAST_IDX) begin
        er <= '0;
        ek <= ek + 2'd1;
      end else begin
        er <= er + 2'd1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_conv, out_rot, out_vec, out_eig, out_comp, out_pair};
  assign m_axis_tlast  = out_last;

endmodule

>>> src/sje_arith.sv
// sje_arith: shared multi-cycle arithmetic unit of the jacobi core
// one op at a time: 33x32 multiply, restoring divide, digit-by-digit square root
// depends on sje_pkg
module sje_arith import sje_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  logic        busy;
  arith_op_t   op_r;
  logic [5:0]  cnt;
  logic        done;
  logic [63:0] res;

  logic [61:0] nreg;
  logic [61:0] quo;
  logic [32:0] rem;
  logic [32:0] den;

  logic [63:0] xr;
  logic [63:0] rr;
  logic [63:0] bitr;

  logic [64:0] prod_full;
  logic [33:0] div_trial;
  logic        div_ge;
  logic [33:0] div_diff;
  logic [61:0] quo_next;
  logic [63:0] sq_sum;
  logic        sq_ge;
  logic [63:0] rr_next;

  assign prod_full = req.a[32:0] * req.b[31:0];
  assign div_trial = {rem, nreg[61]};
  assign div_ge    = div_trial >= {1'b0, den};
  assign div_diff  = div_trial - {1'b0, den};
  assign quo_next  = {quo[60:0], div_ge};
  assign sq_sum    = rr + bitr;
  assign sq_ge     = xr >= sq_sum;
  assign rr_next   = sq_ge ? ((rr >> 1) + bitr) : (rr >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op_r <= ARITH_MUL;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start) begin
        op_r <= req.op;
        case (req.op)
          ARITH_DIV: begin
            busy <= 1'b1;
            cnt  <= 6'(DIV_STEPS - 1);
          end
          ARITH_SQRT: begin
            busy <= 1'b1;
            cnt  <= 6'(SQRT_STEPS - 1);
          end
          default: done <= 1'b1;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (busy) begin
      case (op_r)
        ARITH_DIV: begin
          rem  <= div_ge ? div_diff[32:0] : div_trial[32:0];
          quo  <= quo_next;
          nreg <= {nreg[60:0], 1'b0};
          if (cnt == 6'd0) res <= {2'b00, quo_next};
        end
        ARITH_SQRT: begin
          xr   <= sq_ge ? (xr - sq_sum) : xr;
          rr   <= rr_next;
          bitr <= bitr >> 2;
          if (cnt == 6'd0) res <= rr_next;
        end
        default: ;
      endcase
    end else if (req.start) begin
      case (req.op)
        ARITH_DIV: begin
          nreg <= req.a[61:0];
          quo  <= '0;
          rem  <= '0;
          den  <= req.b[32:0];
        end
        ARITH_SQRT: begin
          xr   <= req.a;
          rr   <= '0;
          bitr <= 64'h4000_0000_0000_0000;
        end
        default: res <= prod_full[63:0];
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

endmodule
